>>> sv/pls_pkg.sv
`timescale 1ns / 1ps
// Package for the positional list store: request and response structs,
// operation and status codes, and the cell control struct.
// No dependencies.
package pls_pkg;

	localparam int PLS_DEPTH = 16;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_FIND   = 2'd2
	} func_e_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_e_t;

	typedef struct packed {
		logic        [1:0]  func;
		logic        [4:0]  position;
		logic signed [31:0] value;
	} pls_req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic        [4:0]  found_at;
		logic        [4:0]  length;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
	} pls_rsp_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_op_t;

endpackage

>>> sv/pls_cell.sv
`timescale 1ns / 1ps
// One storage cell of the positional list store: holds one entry, shifts
// from its neighbors on insert and remove, and compares against a search key.
// Depends on pls_pkg.
module pls_cell import pls_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  cell_op_t           op,
	input  logic [CW-1:0]      pos,
	input  logic [CW-1:0]      count,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic signed [31:0] key,
	output logic signed [31:0] data,
	output logic               match,
	output logic signed [31:0] back
);

	logic signed [31:0] data_q;
	logic [CW-1:0]      my_idx;
	logic [CW-1:0]      my_next;

	assign my_idx  = CW'(IDX);
	assign my_next = CW'(IDX + 1);

	always_ff @(posedge clk) begin
		priority if (op.ins && my_idx == pos) begin
			data_q <= value;
		end else if (op.ins && my_idx > pos) begin
			data_q <= left;
		end else if (op.rem && my_idx >= pos) begin
			data_q <= right;
		end else begin
			data_q <= data_q;
		end
	end

	assign data  = data_q;
	assign match = (data_q == key) && (my_idx < count);
	assign back  = (my_next == count) ? data_q : '0;

endmodule

>>> sv/positional_list_store.sv
`timescale 1ns / 1ps
// Positional list store: an ordered list of up to DEPTH signed 32-bit values
// held in a row of cells. Each request inserts at an index (past the end
// appends), removes at an index, or finds the first index of a value, and
// yields one response with status, find index, length and front/back values.
// The cells shift on the accepting edge, then the cells compare and the
// first-match encoder and back-value select fill the response register.
// One request is in flight at a time; a new request is taken while the
// previous response waits. Depends on pls_pkg and pls_cell.
module positional_list_store import pls_pkg::*; #(
	parameter int DEPTH = PLS_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pls_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pls_rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	logic [CW-1:0]      count_q;
	logic               s1_valid_q;
	func_e_t            func_s1;
	status_e_t          status_s1;
	logic signed [31:0] key_s1;
	logic               rsp_valid_q;
	pls_rsp_t           rsp_q;
	pls_rsp_t           rsp_d;

	logic               accept;
	logic               advance;
	logic [PW-1:0]      pos_w;
	logic [PW-1:0]      cnt_w;
	logic               full;
	logic               in_range;
	logic [CW-1:0]      pos_c;
	cell_op_t           op;
	status_e_t          status_d;
	logic [CW-1:0]      found_idx;
	logic signed [31:0] back_val;

	logic signed [31:0] cell_data [DEPTH];
	logic signed [31:0] cell_back [DEPTH];
	logic [DEPTH-1:0]   cell_match;

	assign accept    = req_valid && !req_stall;
	assign req_stall = s1_valid_q;
	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);

	assign pos_w    = PW'(req.position);
	assign cnt_w    = PW'(count_q);
	assign full     = count_q >= CW'(DEPTH);
	assign in_range = pos_w < cnt_w;
	assign pos_c    = (pos_w > cnt_w) ? count_q : CW'(pos_w);

	always_comb begin
		op.ins   = 1'b0;
		op.rem   = 1'b0;
		status_d = ST_DONE;
		unique case (func_e_t'(req.func))
			FUNC_INSERT: begin
				op.ins   = accept && !full;
				status_d = full ? ST_FULL : ST_DONE;
			end
			FUNC_REMOVE: begin
				op.rem   = accept && in_range;
				status_d = in_range ? ST_DONE : ST_RANGE;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic signed [31:0] left_d;
			logic signed [31:0] right_d;
			if (g == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_left
				assign left_d = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_right
				assign right_d = cell_data[g+1];
			end
			pls_cell #(
				.IDX (g),
				.CW  (CW)
			) u_cell (
				.clk   (clk),
				.op    (op),
				.pos   (pos_c),
				.count (count_q),
				.value (req.value),
				.left  (left_d),
				.right (right_d),
				.key   (key_s1),
				.data  (cell_data[g]),
				.match (cell_match[g]),
				.back  (cell_back[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.ins) begin
			count_q <= count_q + CW'(1);
		end else if (op.rem) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func_e_t'(req.func);
			status_s1 <= status_d;
			key_s1    <= req.value;
		end
	end

	// first matching cell wins
	always_comb begin
		found_idx = count_q;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				found_idx = CW'(i);
			end
		end
	end

	always_comb begin
		back_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_val = back_val | cell_back[i];
		end
	end

	always_comb begin
		rsp_d.status      = status_s1;
		rsp_d.found_at    = (func_s1 == FUNC_FIND) ? 5'(found_idx) : 5'd0;
		rsp_d.length      = 5'(count_q);
		rsp_d.front_value = (count_q != '0) ? cell_data[0] : '0;
		rsp_d.back_value  = back_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/pls_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store.
module pls_checker import pls_pkg::*; #(
	parameter int DEPTH = PLS_DEPTH
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input pls_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input pls_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response without a request");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.length == 5'(DEPTH))
		else $error("full refusal with list not full");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (DEPTH < 32) |-> rsp.length <= 5'(DEPTH))
		else $error("length beyond depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (DEPTH < 32) && rsp.length == 5'd0
		|-> rsp.front_value == 0 && rsp.back_value == 0)
		else $error("empty list with nonzero front or back");

endmodule

bind positional_list_store pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);
